// ===== rtl/pmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion package
// Shared word types, register indexes, command codes and saturation helpers.
// ----------------------------------------------------------------------------
package pmf_pkg;

  typedef struct packed {
    logic              optical_ok;
    logic              motion_seen;
    logic              on_surface;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic              heading_ok;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic signed [7:0]  zoom_level;
    logic signed [7:0]  scroll_delta;
    logic [1:0]        button_state;
  } pmf_in_t;

  typedef struct packed {
    logic              report_valid;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_step;
    logic [1:0]        button_bits;
    logic              rezero_imu;
  } pmf_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CPI      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZSTEPS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZSPAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEADLESS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFX     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFY     = 3'd7;

  // Multiply-divide unit and datapath widths.
  localparam int MD_A_W = 35;
  localparam int MD_M_W = 33;
  localparam int MD_D_W = 35;
  localparam int MD_Q_W = 64;
  localparam int MD_R_W = 65;
  localparam int SUM_W  = 67;
  localparam int TRIG_W = 17;
  localparam int ACC_W  = 34;
  localparam int SENS_W = 28;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_PRE   = 3'd2;
  localparam logic [OP_W-1:0] OP_SMUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_MD    = 3'd4;
  localparam logic [OP_W-1:0] OP_PXSET = 3'd5;
  localparam logic [OP_W-1:0] OP_SENSB = 3'd6;
  localparam logic [OP_W-1:0] OP_OUT   = 3'd7;

  localparam int SM_W = 3;
  localparam logic [SM_W-1:0] SM_PXA = 3'd0;
  localparam logic [SM_W-1:0] SM_PXB = 3'd1;
  localparam logic [SM_W-1:0] SM_PYA = 3'd2;
  localparam logic [SM_W-1:0] SM_PYB = 3'd3;
  localparam logic [SM_W-1:0] SM_RXA = 3'd4;
  localparam logic [SM_W-1:0] SM_RXB = 3'd5;
  localparam logic [SM_W-1:0] SM_RYA = 3'd6;
  localparam logic [SM_W-1:0] SM_RYB = 3'd7;

  localparam int JOB_W = 4;
  localparam logic [JOB_W-1:0] J_PXT_X = 4'd0;
  localparam logic [JOB_W-1:0] J_PXT_Y = 4'd1;
  localparam logic [JOB_W-1:0] J_ERRX  = 4'd2;
  localparam logic [JOB_W-1:0] J_ERRY  = 4'd3;
  localparam logic [JOB_W-1:0] J_OX    = 4'd4;
  localparam logic [JOB_W-1:0] J_OY    = 4'd5;
  localparam logic [JOB_W-1:0] J_PSX   = 4'd6;
  localparam logic [JOB_W-1:0] J_PSY   = 4'd7;
  localparam logic [JOB_W-1:0] J_SENS  = 4'd8;
  localparam logic [JOB_W-1:0] J_SX    = 4'd9;
  localparam logic [JOB_W-1:0] J_SY    = 4'd10;
  localparam logic [JOB_W-1:0] J_ESX   = 4'd11;
  localparam logic [JOB_W-1:0] J_ESY   = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SM_W-1:0]  sm;
    logic [JOB_W-1:0] job;
  } pmf_cmd_t;

  typedef struct packed {
    logic pend;
    logic lifted;
    logic moving;
    logic head_hl;
    logic pok;
    logic steps_zero;
    logic md_done;
  } pmf_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > 67'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -67'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [7:0] clamp_hid(input logic signed [SUM_W-1:0] v);
    if (v > 67'sd127) begin
      return 8'sd127;
    end else if (v < -67'sd127) begin
      return -8'sd127;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

// ===== rtl/pmf_muldiv.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion multiply-divide unit
// Computes round(a*m/d), half away from zero, with a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module pmf_muldiv import pmf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MD_A_W-1:0] a,
  input  logic [MD_M_W-1:0]        m,
  input  logic [MD_D_W-1:0]        d,
  output logic                     done,
  output logic signed [MD_R_W-1:0] res
);

  localparam int P_W = MD_A_W + MD_M_W;
  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_ADD  = 2'd2;
  localparam logic [1:0] MD_DIV  = 2'd3;
  localparam logic [5:0] DIV_LAST = 6'(MD_Q_W - 1);

  logic [1:0]        state_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic              neg_r;
  logic [MD_A_W-1:0] mag_r;
  logic [MD_M_W-1:0] m_r;
  logic [MD_D_W-1:0] d_r;
  logic [MD_Q_W-1:0] prod_r;
  logic [MD_Q_W-1:0] num_r;
  logic [MD_D_W-1:0] rem_r;
  logic [P_W-1:0]    prod_full;
  logic [MD_D_W:0]   trial;
  logic              fits;

  assign prod_full = P_W'(mag_r) * P_W'(m_r);
  assign trial     = {rem_r, num_r[MD_Q_W-1]};
  assign fits      = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MD_IDLE: begin
          if (start) begin
            state_r <= MD_MUL;
          end
        end
        MD_MUL: state_r <= MD_ADD;
        MD_ADD: begin
          cnt_r   <= '0;
          state_r <= MD_DIV;
        end
        MD_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= MD_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          neg_r <= a[MD_A_W-1];
          mag_r <= a[MD_A_W-1] ? MD_A_W'(-a) : MD_A_W'(a);
          m_r   <= m;
          d_r   <= d;
        end
      end
      MD_MUL: prod_r <= prod_full[MD_Q_W-1:0];
      MD_ADD: begin
        num_r <= prod_r + MD_Q_W'(d_r >> 1);
        rem_r <= '0;
      end
      MD_DIV: begin
        // Quotient bits shift in at the bottom as the dividend shifts out.
        num_r <= {num_r[MD_Q_W-2:0], fits};
        rem_r <= fits ? MD_D_W'(trial - {1'b0, d_r}) : trial[MD_D_W-1:0];
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});

endmodule

// ===== rtl/pmf_datapath.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion datapath
// Configuration, frame state, rotation multiplier and the multiply-divide unit.
// ----------------------------------------------------------------------------
module pmf_datapath import pmf_pkg::*; #(
  parameter int MM_FRAC_BITS   = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pmf_in_t               in_data,
  input  pmf_cmd_t              cmd,
  output pmf_stat_t             stat,
  output pmf_out_t              out_data
);

  localparam logic [MD_M_W-1:0] K_MM_M   = MD_M_W'(254) << MM_FRAC_BITS;
  localparam logic [MD_D_W-1:0] K_MM_D   = MD_D_W'(254) << MM_FRAC_BITS;
  localparam logic [MD_M_W-1:0] K_UNIT_M = MD_M_W'(1) << (MM_FRAC_BITS + 8);
  localparam logic [MD_D_W-1:0] K_UNIT_D = MD_D_W'(1) << (MM_FRAC_BITS + 8);
  localparam logic [MD_M_W-1:0] K_PXT_M  = MD_M_W'(1) << MM_FRAC_BITS;
  localparam logic [MD_D_W-1:0] K_PXT_D  = MD_D_W'(1) << (TRIG_FRAC_BITS + 8);
  localparam logic signed [TRIG_W-1:0] K_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

  // Configuration registers.
  logic [14:0]        cpi_r;
  logic [15:0]        base_r;
  logic [6:0]         zsteps_r;
  logic [11:0]        zspan_r;
  logic [1:0]         turn_r;
  logic               hl_r;
  logic signed [15:0] offx_r, offy_r;
  logic               pend_r;

  // Frame state.
  logic                     lifted_r, pok_r;
  logic signed [TRIG_W-1:0] hc_r, hs_r;
  logic signed [31:0]       ex_r, ey_r, px_r, py_r;
  logic [1:0]               lastb_r;

  // Per-word working registers.
  pmf_in_t                  in_r;
  pmf_out_t                 out_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [31:0]       tx_r, ty_r;
  logic signed [7:0]        ox_r, oy_r, sx_r, sy_r;
  logic [SENS_W-1:0]        sens_r;
  logic                     changed_r, tdown_r;
  logic [JOB_W-1:0]         job_r;

  logic [14:0]               cpi_eff;
  logic [18:0]               cpi10;
  logic signed [TRIG_W-1:0]  dx, dy, rx, ry, c_eff, s_eff, sm_t, sm_b;
  logic signed [ACC_W-1:0]   sm_prod;
  logic signed [20:0]        zprod, znum;
  logic                      md_start, md_done;
  logic signed [MD_A_W-1:0]  md_a;
  logic [MD_M_W-1:0]         md_m;
  logic [MD_D_W-1:0]         md_d;
  logic signed [MD_R_W-1:0]  md_res;
  logic signed [SUM_W-1:0]   res_w;
  logic                      td;
  logic signed [7:0]         mx, my, wheel;
  logic                      rep;

  assign cpi_eff = (cpi_r == 15'd0) ? 15'd1 : cpi_r;
  assign cpi10   = {1'b0, cpi_eff, 3'b000} + {3'b000, cpi_eff, 1'b0};

  assign dx = TRIG_W'(in_r.delta_x);
  assign dy = TRIG_W'(in_r.delta_y);

  always_comb begin
    case (turn_r)
      2'd1:    begin rx = dy;  ry = -dx; end
      2'd2:    begin rx = -dx; ry = -dy; end
      2'd3:    begin rx = -dy; ry = dx;  end
      default: begin rx = dx;  ry = dy;  end
    endcase
  end

  assign c_eff = hl_r ? hc_r : K_ONE;
  assign s_eff = hl_r ? hs_r : '0;

  always_comb begin
    case (cmd.sm)
      SM_PXA:  begin sm_t = hc_r;  sm_b = TRIG_W'(offx_r); end
      SM_PXB:  begin sm_t = hs_r;  sm_b = TRIG_W'(offy_r); end
      SM_PYA:  begin sm_t = hs_r;  sm_b = TRIG_W'(offx_r); end
      SM_PYB:  begin sm_t = hc_r;  sm_b = TRIG_W'(offy_r); end
      SM_RXA:  begin sm_t = c_eff; sm_b = rx; end
      SM_RXB:  begin sm_t = s_eff; sm_b = ry; end
      SM_RYA:  begin sm_t = s_eff; sm_b = rx; end
      default: begin sm_t = c_eff; sm_b = ry; end
    endcase
  end

  assign sm_prod = sm_t * sm_b;

  assign zprod = in_r.zoom_level * $signed({1'b0, zspan_r});
  assign znum  = zprod + $signed({6'b0, zsteps_r, 8'b0});

  always_comb begin
    md_a = MD_A_W'(acc_r);
    md_m = K_PXT_M;
    md_d = K_PXT_D;
    case (cmd.job)
      J_PXT_X, J_PXT_Y: ;
      J_ERRX, J_ERRY: begin
        md_m = K_MM_M;
        md_d = MD_D_W'(cpi10) << TRIG_FRAC_BITS;
      end
      J_OX: begin
        md_a = MD_A_W'(tx_r) - MD_A_W'(px_r);
        md_m = MD_M_W'(cpi10);
        md_d = K_MM_D;
      end
      J_OY: begin
        md_a = MD_A_W'(ty_r) - MD_A_W'(py_r);
        md_m = MD_M_W'(cpi10);
        md_d = K_MM_D;
      end
      J_PSX, J_PSY: begin
        md_a = (cmd.job == J_PSX) ? MD_A_W'(ox_r) : MD_A_W'(oy_r);
        md_m = K_MM_M;
        md_d = MD_D_W'(cpi10);
      end
      J_SENS: begin
        md_a = MD_A_W'(znum);
        md_m = MD_M_W'(base_r);
        md_d = MD_D_W'({zsteps_r, 8'b0});
      end
      J_SX, J_SY: begin
        md_a = (cmd.job == J_SX) ? MD_A_W'(ex_r) : MD_A_W'(ey_r);
        md_m = MD_M_W'(sens_r);
        md_d = K_UNIT_D;
      end
      J_ESX, J_ESY: begin
        md_a = (cmd.job == J_ESX) ? MD_A_W'(sx_r) : MD_A_W'(sy_r);
        md_m = K_UNIT_M;
        md_d = MD_D_W'(sens_r);
      end
      default: ;
    endcase
  end

  assign md_start = (cmd.op == OP_MD);

  pmf_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .m     (md_m),
    .d     (md_d),
    .done  (md_done),
    .res   (md_res)
  );

  assign res_w = SUM_W'(md_res);
  assign td    = in_r.optical_ok && lifted_r && in_r.on_surface;

  // Configuration writes; an offset write leaves the proxy to be recomputed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpi_r    <= 15'd1600;
      base_r   <= 16'd2560;
      zsteps_r <= '0;
      zspan_r  <= '0;
      turn_r   <= '0;
      hl_r     <= 1'b0;
      offx_r   <= '0;
      offy_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cmd.op == OP_PXSET) begin
        pend_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_CPI:      cpi_r    <= cfg_data[14:0];
          REG_BASE:     base_r   <= cfg_data;
          REG_ZSTEPS:   zsteps_r <= cfg_data[6:0];
          REG_ZSPAN:    zspan_r  <= cfg_data[11:0];
          REG_TURN:     turn_r   <= cfg_data[1:0];
          REG_HEADLESS: hl_r     <= cfg_data[0];
          REG_OFFX: begin
            offx_r <= $signed(cfg_data);
            pend_r <= 1'b1;
          end
          REG_OFFY: begin
            offy_r <= $signed(cfg_data);
            pend_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // State carried from frame to frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifted_r <= 1'b1;
      pok_r    <= 1'b0;
      hc_r     <= K_ONE;
      hs_r     <= '0;
      ex_r     <= '0;
      ey_r     <= '0;
      px_r     <= '0;
      py_r     <= '0;
      lastb_r  <= '0;
    end else begin
      case (cmd.op)
        OP_PRE: begin
          lastb_r <= in_r.button_state;
          if (in_r.optical_ok) begin
            lifted_r <= !in_r.on_surface;
          end
          if (td) begin
            hc_r  <= K_ONE;
            hs_r  <= '0;
            pok_r <= 1'b0;
          end else if (in_r.heading_ok) begin
            hc_r <= TRIG_W'(in_r.heading_cos);
            hs_r <= TRIG_W'(in_r.heading_sin);
          end
        end
        OP_PXSET: begin
          px_r  <= tx_r;
          py_r  <= ty_r;
          pok_r <= 1'b1;
        end
        default: ;
      endcase
      if (md_done) begin
        case (job_r)
          J_ERRX: ex_r <= sat32(SUM_W'(ex_r) + res_w);
          J_ERRY: ey_r <= sat32(SUM_W'(ey_r) + res_w);
          J_PSX:  px_r <= sat32(SUM_W'(px_r) + res_w);
          J_PSY:  py_r <= sat32(SUM_W'(py_r) + res_w);
          J_ESX:  ex_r <= sat32(SUM_W'(ex_r) - res_w);
          J_ESY:  ey_r <= sat32(SUM_W'(ey_r) - res_w);
          default: ;
        endcase
      end
    end
  end

  // Working registers for the word in flight.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: in_r <= in_data;
      OP_PRE: begin
        changed_r <= in_r.button_state != lastb_r;
        tdown_r   <= td;
        ox_r      <= '0;
        oy_r      <= '0;
        sx_r      <= '0;
        sy_r      <= '0;
      end
      OP_SMUL: begin
        if (cmd.sm == SM_PXA || cmd.sm == SM_PYA || cmd.sm == SM_RXA ||
            cmd.sm == SM_RYA) begin
          acc_r <= sm_prod;
        end else if (cmd.sm == SM_PXB || cmd.sm == SM_RXB) begin
          acc_r <= acc_r - sm_prod;
        end else begin
          acc_r <= acc_r + sm_prod;
        end
      end
      OP_MD:    job_r  <= cmd.job;
      OP_SENSB: sens_r <= (base_r == 16'd0) ? SENS_W'(1) : SENS_W'(base_r);
      OP_OUT:   out_r  <= '{rep, rep ? mx : 8'sd0, rep ? my : 8'sd0,
                            rep ? wheel : 8'sd0, rep ? in_r.button_state : 2'b00,
                            tdown_r};
      default: ;
    endcase
    if (md_done) begin
      case (job_r)
        J_PXT_X: tx_r <= sat32(res_w);
        J_PXT_Y: ty_r <= sat32(res_w);
        J_OX:    ox_r <= clamp_hid(res_w);
        J_OY:    oy_r <= clamp_hid(res_w);
        J_SX:    sx_r <= clamp_hid(res_w);
        J_SY:    sy_r <= clamp_hid(res_w);
        J_SENS: begin
          if (res_w < 67'sd1) begin
            sens_r <= SENS_W'(1);
          end else if (res_w > 67'sd268435455) begin
            sens_r <= '1;
          end else begin
            sens_r <= res_w[SENS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign mx    = clamp_hid(SUM_W'(ox_r) + SUM_W'(sx_r));
  assign my    = clamp_hid(SUM_W'(oy_r) + SUM_W'(sy_r));
  assign wheel = (in_r.scroll_delta == -8'sd128) ? -8'sd127 : in_r.scroll_delta;
  assign rep   = (mx != 8'sd0) || (my != 8'sd0) || (wheel != 8'sd0) || changed_r;

  assign stat.pend       = pend_r;
  assign stat.lifted     = lifted_r;
  assign stat.moving     = in_r.optical_ok && in_r.motion_seen;
  assign stat.head_hl    = in_r.heading_ok && hl_r;
  assign stat.pok        = pok_r;
  assign stat.steps_zero = (zsteps_r == 7'd0);
  assign stat.md_done    = md_done;

  assign out_data = out_r;

endmodule

// ===== rtl/pmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion controller
// Sequences one word through the datapath and drives both handshakes.
// ----------------------------------------------------------------------------
module pmf_ctrl import pmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pmf_stat_t stat,
  output pmf_cmd_t  cmd
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
  localparam logic [ST_W-1:0] ST_CP0  = 5'd1;
  localparam logic [ST_W-1:0] ST_CP1  = 5'd2;
  localparam logic [ST_W-1:0] ST_CP2  = 5'd3;
  localparam logic [ST_W-1:0] ST_CP3  = 5'd4;
  localparam logic [ST_W-1:0] ST_CP4  = 5'd5;
  localparam logic [ST_W-1:0] ST_CP5  = 5'd6;
  localparam logic [ST_W-1:0] ST_CP6  = 5'd7;
  localparam logic [ST_W-1:0] ST_PRE  = 5'd8;
  localparam logic [ST_W-1:0] ST_BR   = 5'd9;
  localparam logic [ST_W-1:0] ST_RT0  = 5'd10;
  localparam logic [ST_W-1:0] ST_RT1  = 5'd11;
  localparam logic [ST_W-1:0] ST_RT2  = 5'd12;
  localparam logic [ST_W-1:0] ST_RT3  = 5'd13;
  localparam logic [ST_W-1:0] ST_RT4  = 5'd14;
  localparam logic [ST_W-1:0] ST_RT5  = 5'd15;
  localparam logic [ST_W-1:0] ST_HD   = 5'd16;
  localparam logic [ST_W-1:0] ST_OX   = 5'd17;
  localparam logic [ST_W-1:0] ST_OY   = 5'd18;
  localparam logic [ST_W-1:0] ST_PS0  = 5'd19;
  localparam logic [ST_W-1:0] ST_PS1  = 5'd20;
  localparam logic [ST_W-1:0] ST_SN   = 5'd21;
  localparam logic [ST_W-1:0] ST_SX   = 5'd22;
  localparam logic [ST_W-1:0] ST_SY   = 5'd23;
  localparam logic [ST_W-1:0] ST_EX   = 5'd24;
  localparam logic [ST_W-1:0] ST_EY   = 5'd25;
  localparam logic [ST_W-1:0] ST_OUT  = 5'd26;
  localparam logic [ST_W-1:0] ST_WAIT = 5'd27;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [ST_W-1:0] ret_r, ret_nxt;
  logic            cfgm_r, cfgm_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cfgm_nxt  = cfgm_r;
    in_ready  = 1'b0;
    cmd       = '{OP_NONE, SM_PXA, J_PXT_X};
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          cfgm_nxt  = stat.pend;
          state_nxt = stat.pend ? ST_CP0 : ST_PRE;
        end
      end
      // Proxy target from the offset, shared by the offset write and the
      // headless step.
      ST_CP0: begin cmd.op = OP_SMUL; cmd.sm = SM_PXA; state_nxt = ST_CP1; end
      ST_CP1: begin cmd.op = OP_SMUL; cmd.sm = SM_PXB; state_nxt = ST_CP2; end
      ST_CP2: begin
        cmd.op = OP_MD; cmd.job = J_PXT_X; ret_nxt = ST_CP3; state_nxt = ST_WAIT;
      end
      ST_CP3: begin cmd.op = OP_SMUL; cmd.sm = SM_PYA; state_nxt = ST_CP4; end
      ST_CP4: begin cmd.op = OP_SMUL; cmd.sm = SM_PYB; state_nxt = ST_CP5; end
      ST_CP5: begin
        cmd.op = OP_MD; cmd.job = J_PXT_Y; ret_nxt = ST_CP6; state_nxt = ST_WAIT;
      end
      ST_CP6: begin
        if (cfgm_r) begin
          cmd.op    = OP_PXSET;
          cfgm_nxt  = 1'b0;
          state_nxt = ST_PRE;
        end else if (stat.pok) begin
          state_nxt = ST_OX;
        end else begin
          cmd.op    = OP_PXSET;
          state_nxt = ST_SN;
        end
      end
      ST_PRE: begin cmd.op = OP_PRE; state_nxt = ST_BR; end
      ST_BR: begin
        if (stat.lifted) begin
          state_nxt = ST_OUT;
        end else if (stat.moving) begin
          state_nxt = ST_RT0;
        end else begin
          state_nxt = ST_HD;
        end
      end
      ST_RT0: begin cmd.op = OP_SMUL; cmd.sm = SM_RXA; state_nxt = ST_RT1; end
      ST_RT1: begin cmd.op = OP_SMUL; cmd.sm = SM_RXB; state_nxt = ST_RT2; end
      ST_RT2: begin
        cmd.op = OP_MD; cmd.job = J_ERRX; ret_nxt = ST_RT3; state_nxt = ST_WAIT;
      end
      ST_RT3: begin cmd.op = OP_SMUL; cmd.sm = SM_RYA; state_nxt = ST_RT4; end
      ST_RT4: begin cmd.op = OP_SMUL; cmd.sm = SM_RYB; state_nxt = ST_RT5; end
      ST_RT5: begin
        cmd.op = OP_MD; cmd.job = J_ERRY; ret_nxt = ST_HD; state_nxt = ST_WAIT;
      end
      ST_HD: state_nxt = stat.head_hl ? ST_CP0 : ST_SN;
      ST_OX: begin
        cmd.op = OP_MD; cmd.job = J_OX; ret_nxt = ST_OY; state_nxt = ST_WAIT;
      end
      ST_OY: begin
        cmd.op = OP_MD; cmd.job = J_OY; ret_nxt = ST_PS0; state_nxt = ST_WAIT;
      end
      ST_PS0: begin
        cmd.op = OP_MD; cmd.job = J_PSX; ret_nxt = ST_PS1; state_nxt = ST_WAIT;
      end
      ST_PS1: begin
        cmd.op = OP_MD; cmd.job = J_PSY; ret_nxt = ST_SN; state_nxt = ST_WAIT;
      end
      ST_SN: begin
        if (stat.steps_zero) begin
          cmd.op    = OP_SENSB;
          state_nxt = ST_SX;
        end else begin
          cmd.op = OP_MD; cmd.job = J_SENS; ret_nxt = ST_SX; state_nxt = ST_WAIT;
        end
      end
      ST_SX: begin
        cmd.op = OP_MD; cmd.job = J_SX; ret_nxt = ST_SY; state_nxt = ST_WAIT;
      end
      ST_SY: begin
        cmd.op = OP_MD; cmd.job = J_SY; ret_nxt = ST_EX; state_nxt = ST_WAIT;
      end
      ST_EX: begin
        cmd.op = OP_MD; cmd.job = J_ESX; ret_nxt = ST_EY; state_nxt = ST_WAIT;
      end
      ST_EY: begin
        cmd.op = OP_MD; cmd.job = J_ESY; ret_nxt = ST_OUT; state_nxt = ST_WAIT;
      end
      ST_OUT: begin
        // The output register may only be refilled once it is empty or
        // being taken in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (stat.md_done) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      cfgm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cfgm_r      <= cfgm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.md_done |-> state_r == ST_WAIT)
    else $error("divider finished outside the wait state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != ST_IDLE)
    else $error("accepted word did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/pointer_motion_fusion_top.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion top level
// Fuses optical motion, IMU heading, wheels and buttons into HID report words.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready/in_data) takes one frame word; the
// output channel (out_valid/out_ready/out_data) returns exactly one report
// word per frame, with report_valid set when the host should be sent one.
// The user writes configuration registers through cfg_we/cfg_idx/cfg_data,
// one per cycle and only while no frame is in flight, unchecked by the block.
// Each frame is processed on its own. A lifted frame goes from the accept
// through the PRE, BR and OUT states, where the result is loaded once the
// output register is free, and then back to idle for the next word. Each job
// of the shared multiply-divide unit develops one quotient bit per cycle over
// 64 bits. A moving headless frame runs 13 jobs, and 2 more when an offset
// was written before it, which is the most jobs that any frame runs.
// The result sits in an output register, so the next frame is accepted while
// it waits; a stalled receiver only holds the block once a second result is
// ready to be loaded.
// Reset (synchronous, active low) restores the configuration, frame state and
// control registers to their defaults, marks the sensor as lifted and sets the
// heading to identity; there is no clearing pass.
// ----------------------------------------------------------------------------
module pointer_motion_fusion_top import pmf_pkg::*; #(
  parameter int MM_FRAC_BITS   = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pmf_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pmf_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pmf_cmd_t  cmd;
  pmf_stat_t stat;

  pmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmf_datapath #(
    .MM_FRAC_BITS   (MM_FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== sim/pointer_motion_fusion_top_tb.sv =====
// ----------------------------------------------------------------------------
// Pointer motion fusion testbench
// Drives frame words through the valid/ready input channel and checks every
// report word against a cycle-free predictor of the fusion arithmetic, or a
// typed report in the directed table that opens the run at reset settings.
// Random frames follow under several settings, bursty input, stalling receiver.
// ----------------------------------------------------------------------------
module pointer_motion_fusion_top_tb;
  import pmf_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    pmf_in_t  frame;
    bit       typed;
    pmf_out_t report;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pmf_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pmf_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_CPI;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_row_t send_q[$];
  pmf_out_t   report_q[$];
  int         fail_cnt = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         stall_cnt = 0;
  frame_row_t cur_row;
  logic [1:0] held_buttons = '0;

  // Mirror of the block's registers and state.
  int unsigned cpi_m, base_m, zsteps_m, zspan_m, turn_m, headless_m;
  int          offx_m, offy_m;
  bit          lifted_m, proxy_ok_m;
  int          head_c_m, head_s_m;
  int          err_x_m, err_y_m, proxy_x_m, proxy_y_m;
  logic [1:0]  buttons_m;

  pointer_motion_fusion_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Scaled division rounded half away from zero.
  function automatic longint scale_round(longint a, longint unsigned mul,
                                         longint unsigned den);
    longint unsigned mag, q;
    mag = (a < 0) ? longint'(-a) : a;
    q = (mag * mul + den / 2) / den;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint clamp_step(longint v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic void aim_proxy();
    longint px, py;
    px = longint'(head_c_m) * offx_m - longint'(head_s_m) * offy_m;
    py = longint'(head_s_m) * offx_m + longint'(head_c_m) * offy_m;
    proxy_x_m = sat_word(scale_round(px, 64'd1 << 16, 64'd1 << 22));
    proxy_y_m = sat_word(scale_round(py, 64'd1 << 16, 64'd1 << 22));
  endfunction

  function automatic longint unsigned zoomed_gain(int zoom);
    longint s, num;
    if (zsteps_m == 0) begin
      s = base_m;
    end else begin
      num = 256 * longint'(zsteps_m) + longint'(zoom) * longint'(zspan_m);
      s = scale_round(num, base_m, 256 * longint'(zsteps_m));
    end
    if (s < 1) s = 1;
    if (s > 64'h0FFFFFFF) s = 64'h0FFFFFFF;
    return s;
  endfunction

  function automatic void mirror_reset();
    cpi_m = 1600; base_m = 2560; zsteps_m = 0; zspan_m = 0; turn_m = 0;
    headless_m = 0; offx_m = 0; offy_m = 0;
    lifted_m = 1; proxy_ok_m = 0; head_c_m = 16384; head_s_m = 0;
    err_x_m = 0; err_y_m = 0; proxy_x_m = 0; proxy_y_m = 0; buttons_m = '0;
  endfunction

  function automatic pmf_out_t predict_report(pmf_in_t f);
    pmf_out_t r;
    bit changed, was, touch, valid;
    longint wheel, mx, my, ox, oy, sx, sy, rx, ry, vx, vy, ex, ey;
    longint unsigned cpi10, gain;
    int keep_x, keep_y;
    wheel = clamp_step(f.scroll_delta);
    changed = f.button_state != buttons_m;
    buttons_m = f.button_state;
    touch = 0; mx = 0; my = 0;
    if (f.heading_ok) begin
      head_c_m = f.heading_cos; head_s_m = f.heading_sin;
    end
    if (f.optical_ok) begin
      was = lifted_m;
      lifted_m = !f.on_surface;
      touch = was && !lifted_m;
    end
    if (touch) begin
      head_c_m = 16384; head_s_m = 0; proxy_ok_m = 0;
    end
    if (!lifted_m) begin
      cpi10 = 10 * ((cpi_m == 0) ? 1 : cpi_m);
      ox = 0; oy = 0;
      if (f.optical_ok && f.motion_seen) begin
        case (turn_m)
          1: begin rx = f.delta_y; ry = -longint'(f.delta_x); end
          2: begin rx = -longint'(f.delta_x); ry = -longint'(f.delta_y); end
          3: begin rx = -longint'(f.delta_y); ry = f.delta_x; end
          default: begin rx = f.delta_x; ry = f.delta_y; end
        endcase
        if (headless_m != 0) begin
          vx = longint'(head_c_m) * rx - longint'(head_s_m) * ry;
          vy = longint'(head_s_m) * rx + longint'(head_c_m) * ry;
        end else begin
          vx = rx * 16384;
          vy = ry * 16384;
        end
        err_x_m = sat_word(longint'(err_x_m) + scale_round(vx, 64'd254 << 16, cpi10 << 14));
        err_y_m = sat_word(longint'(err_y_m) + scale_round(vy, 64'd254 << 16, cpi10 << 14));
      end
      if (f.heading_ok && headless_m != 0) begin
        if (!proxy_ok_m) begin
          aim_proxy();
          proxy_ok_m = 1;
        end else begin
          keep_x = proxy_x_m; keep_y = proxy_y_m;
          aim_proxy();
          ex = longint'(proxy_x_m) - keep_x;
          ey = longint'(proxy_y_m) - keep_y;
          ox = clamp_step(scale_round(ex, cpi10, 64'd254 << 16));
          oy = clamp_step(scale_round(ey, cpi10, 64'd254 << 16));
          proxy_x_m = sat_word(longint'(keep_x) + scale_round(ox, 64'd254 << 16, cpi10));
          proxy_y_m = sat_word(longint'(keep_y) + scale_round(oy, 64'd254 << 16, cpi10));
        end
      end
      gain = zoomed_gain(f.zoom_level);
      sx = clamp_step(scale_round(err_x_m, gain, 64'd1 << 24));
      sy = clamp_step(scale_round(err_y_m, gain, 64'd1 << 24));
      err_x_m = sat_word(longint'(err_x_m) - scale_round(sx, 64'd1 << 24, gain));
      err_y_m = sat_word(longint'(err_y_m) - scale_round(sy, 64'd1 << 24, gain));
      mx = clamp_step(ox + sx);
      my = clamp_step(oy + sy);
    end
    valid = mx != 0 || my != 0 || wheel != 0 || changed;
    r = '0;
    r.report_valid = valid;
    if (valid) begin
      r.move_x = mx[7:0]; r.move_y = my[7:0];
      r.wheel_step = wheel[7:0]; r.button_bits = f.button_state;
    end
    r.rezero_imu = touch;
    return r;
  endfunction

  function automatic pmf_in_t mk_frame(bit ok, bit mot, bit surf, int dx, int dy,
                                       bit hok, int hc, int hs, int zoom,
                                       int scroll, int btn);
    pmf_in_t f;
    f.optical_ok = ok; f.motion_seen = mot; f.on_surface = surf;
    f.delta_x = dx[15:0]; f.delta_y = dy[15:0]; f.heading_ok = hok;
    f.heading_cos = hc[15:0]; f.heading_sin = hs[15:0];
    f.zoom_level = zoom[7:0]; f.scroll_delta = scroll[7:0];
    f.button_state = btn[1:0];
    return f;
  endfunction

  function automatic pmf_out_t mk_report(bit v, int mx, int my, int wh, int btn, bit rz);
    pmf_out_t r;
    r.report_valid = v; r.move_x = mx[7:0]; r.move_y = my[7:0];
    r.wheel_step = wh[7:0]; r.button_bits = btn[1:0]; r.rezero_imu = rz;
    return r;
  endfunction

  task automatic queue_frame(pmf_in_t f, bit typed = 0, pmf_out_t r = '0);
    frame_row_t row;
    row.frame = f; row.typed = typed; row.report = r;
    send_q.push_back(row);
  endtask

  function automatic pmf_in_t random_frame();
    pmf_in_t f;
    int angle;
    int cs[8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
    int sn[8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};
    f = '0;
    f.optical_ok = $urandom_range(0, 99) < 90;
    f.on_surface = $urandom_range(0, 99) < 85;
    f.motion_seen = $urandom_range(0, 99) < 80;
    if ($urandom_range(0, 9) == 0) begin
      f.delta_x = 16'($urandom); f.delta_y = 16'($urandom);
    end else begin
      f.delta_x = 16'($urandom_range(0, 400) - 200);
      f.delta_y = 16'($urandom_range(0, 400) - 200);
    end
    f.heading_ok = $urandom_range(0, 99) < 70;
    angle = $urandom_range(0, 7);
    if ($urandom_range(0, 4) == 0) begin
      f.heading_cos = 16'($urandom_range(0, 32768) - 16384);
      f.heading_sin = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      f.heading_cos = 16'(cs[angle]); f.heading_sin = 16'(sn[angle]);
    end
    f.zoom_level = 8'($urandom);
    f.scroll_delta = ($urandom_range(0, 9) < 3) ? 8'($urandom) : 8'sd0;
    if ($urandom_range(0, 4) == 0) held_buttons = 2'($urandom);
    f.button_state = held_buttons;
    return f;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val[15:0];
    case (idx)
      REG_CPI:      cpi_m = val & 16'h7FFF;
      REG_BASE:     base_m = val & 16'hFFFF;
      REG_ZSTEPS:   zsteps_m = val & 7'h7F;
      REG_ZSPAN:    zspan_m = val & 12'hFFF;
      REG_TURN:     turn_m = val & 2'h3;
      REG_HEADLESS: headless_m = val & 1;
      REG_OFFX:     begin offx_m = $signed(val[15:0]); end
      REG_OFFY:     begin offy_m = $signed(val[15:0]); end
      default: ;
    endcase
    if (idx == REG_OFFX || idx == REG_OFFY) begin
      aim_proxy();
      proxy_ok_m = 1;
    end
    @(posedge clk);
  endtask

  task automatic set_all(int cpi, int base, int zs, int zspan, int turn, int hl,
                         int offx, int offy);
    write_reg(REG_CPI, cpi); write_reg(REG_BASE, base);
    write_reg(REG_ZSTEPS, zs); write_reg(REG_ZSPAN, zspan);
    write_reg(REG_TURN, turn); write_reg(REG_HEADLESS, hl);
    write_reg(REG_OFFX, offx); write_reg(REG_OFFY, offy);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (send_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Input side: bursts of words separated by random gaps.
  always @(posedge clk) begin
    logic     next_valid;
    pmf_out_t pred_r;
    next_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred_r = predict_report(cur_row.frame);
        report_q.push_back(cur_row.typed ? cur_row.report : pred_r);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() != 0) begin
          cur_row = send_q.pop_front();
          in_data <= cur_row.frame;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // Output side: out_ready follows a random stall pattern, redrawn as stall_cnt runs.
  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_cnt % 4) != 0;
      default: out_ready <= (stall_cnt % 32) >= 20;
    endcase
  end

  always @(posedge clk) begin
    pmf_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: report word with none expected, got %h", $time, out_data);
        fail_cnt++;
      end else begin
        exp_r = report_q.pop_front();
        check_field("report_valid", exp_r.report_valid, out_data.report_valid);
        check_field("move_x", exp_r.move_x, out_data.move_x);
        check_field("move_y", exp_r.move_y, out_data.move_y);
        check_field("wheel_step", exp_r.wheel_step, out_data.wheel_step);
        check_field("button_bits", exp_r.button_bits, out_data.button_bits);
        check_field("rezero_imu", exp_r.rezero_imu, out_data.rezero_imu);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    mirror_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings; lifted frames first, so reports are plain to read.
    queue_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_report(0, 0, 0, 0, 0, 0));
    queue_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, mk_report(1, 0, 0, 0, 1, 0));
    queue_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 127, 2), 1,
                mk_report(1, 0, 0, 127, 2, 0));
    queue_frame(mk_frame(0, 1, 1, 32767, 32767, 0, 0, 0, 0, -128, 2), 1,
                mk_report(1, 0, 0, -127, 2, 0));
    queue_frame(mk_frame(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 2), 1, mk_report(0, 0, 0, 0, 0, 1));
    queue_frame(mk_frame(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 2), 1, mk_report(0, 0, 0, 0, 0, 0));
    queue_frame(mk_frame(1, 1, 1, 32767, -32768, 0, 0, 0, 127, 0, 2));
    queue_frame(mk_frame(1, 1, 1, -32768, 32767, 1, -16384, 16384, -128, 0, 3));
    queue_frame(mk_frame(1, 1, 1, 1, -1, 1, 16384, -16384, 0, 0, 3));
    queue_frame(mk_frame(1, 1, 1, 100, 50, 0, 0, 0, 0, -1, 0));
    queue_frame(mk_frame(0, 1, 1, 300, 300, 0, 0, 0, 0, 0, 0));
    queue_frame(mk_frame(1, 1, 0, 500, 500, 0, 0, 0, 0, 0, 1));
    queue_frame(mk_frame(1, 1, 1, -7, 9, 1, 11585, 11585, 0, 0, 1));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(100, 65535, 127, 4095, 1, 1, 32767, -32768);
        1: set_all(25600, 1, 1, 4095, 2, 0, 0, 0);
        2: set_all(0, 2560, 0, 0, 3, 1, -32768, 32767);
        default: set_all($urandom_range(100, 25600), $urandom_range(1, 65535),
                         $urandom_range(0, 127), $urandom_range(0, 4095),
                         $urandom_range(0, 3), $urandom_range(0, 1),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      repeat (PHASE_ITEMS) queue_frame(random_frame());
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pmf_pkg.sv
rtl/pmf_muldiv.sv
rtl/pmf_datapath.sv
rtl/pmf_ctrl.sv
rtl/pointer_motion_fusion_top.sv
sim/pointer_motion_fusion_top_tb.sv
